/* sv/exlex_pkg.sv */
// ----------------------------------------------------------------------------
// exlex_pkg
// Types, codes and character classes shared by the expression lexer files.
// ----------------------------------------------------------------------------
package exlex_pkg;

	localparam int MAX_LINE   = 65536;
	localparam int CNT_W      = $clog2(MAX_LINE + 1);
	localparam int POS_W      = 17;
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_TOKEN  = 3'd0,
		ST_DONE   = 3'd1,
		ST_BADNUM = 3'd2,
		ST_BANG   = 3'd3,
		ST_LONG   = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		TK_VAR    = 5'd0,
		TK_NUM    = 5'd1,
		TK_COMMA  = 5'd2,
		TK_SEMI   = 5'd3,
		TK_LPAR   = 5'd4,
		TK_RPAR   = 5'd5,
		TK_POW    = 5'd6,
		TK_MUL    = 5'd7,
		TK_DIV    = 5'd8,
		TK_ADD    = 5'd9,
		TK_SUB    = 5'd10,
		TK_ASSIGN = 5'd11,
		TK_EQ     = 5'd12,
		TK_NEQ    = 5'd13,
		TK_LT     = 5'd14,
		TK_LE     = 5'd15,
		TK_GT     = 5'd16,
		TK_GE     = 5'd17,
		TK_AND    = 5'd18,
		TK_OR     = 5'd19,
		TK_NOT    = 5'd20,
		TK_IF     = 5'd21,
		TK_ELSE   = 5'd22
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NAME = 3'd1,
		MODE_NUM  = 3'd2,
		MODE_EQ   = 3'd3,
		MODE_LT   = 3'd4,
		MODE_GT   = 3'd5,
		MODE_BANG = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		KW_NONE = 4'd0,
		KW_A    = 4'd1,
		KW_AN   = 4'd2,
		KW_AND  = 4'd3,
		KW_O    = 4'd4,
		KW_OR   = 4'd5,
		KW_N    = 4'd6,
		KW_NO   = 4'd7,
		KW_NOT  = 4'd8,
		KW_I    = 4'd9,
		KW_IF   = 4'd10,
		KW_E    = 4'd11,
		KW_EL   = 4'd12,
		KW_ELS  = 4'd13,
		KW_ELSE = 4'd14
	} kw_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_line;
	} lex_in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [4:0]       token_kind;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] end_pos;
		logic             final_result;
	} lex_out_t;

	typedef struct packed {
		logic     emit;
		logic     closes;
		lex_out_t item;
	} flush_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
		logic [CNT_W+POS_W-1:0] w;
		w = {{POS_W{1'b0}}, v};
		return w[POS_W-1:0];
	endfunction

	function automatic kw_t kw_first(input logic [7:0] c);
		kw_t r;
		unique case (c)
			"a":     r = KW_A;
			"o":     r = KW_O;
			"n":     r = KW_N;
			"i":     r = KW_I;
			"e":     r = KW_E;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

	function automatic kw_t kw_next(input kw_t st, input logic [7:0] c);
		kw_t r;
		r = KW_NONE;
		unique case (st)
			KW_A:    if (c == "n") r = KW_AN;
			KW_AN:   if (c == "d") r = KW_AND;
			KW_O:    if (c == "r") r = KW_OR;
			KW_N:    if (c == "o") r = KW_NO;
			KW_NO:   if (c == "t") r = KW_NOT;
			KW_I:    if (c == "f") r = KW_IF;
			KW_E:    if (c == "l") r = KW_EL;
			KW_EL:   if (c == "s") r = KW_ELS;
			KW_ELS:  if (c == "e") r = KW_ELSE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

	function automatic kind_t kw_kind(input kw_t st);
		kind_t r;
		unique case (st)
			KW_AND:  r = TK_AND;
			KW_OR:   r = TK_OR;
			KW_NOT:  r = TK_NOT;
			KW_IF:   r = TK_IF;
			KW_ELSE: r = TK_ELSE;
			default: r = TK_VAR;
		endcase
		return r;
	endfunction

	function automatic lex_out_t mk_token(input kind_t k, input logic [CNT_W-1:0] s,
			input logic [CNT_W-1:0] e);
		lex_out_t r;
		r.status       = ST_TOKEN;
		r.token_kind   = k;
		r.start_pos    = to_pos(s);
		r.end_pos      = to_pos(e);
		r.final_result = 1'b0;
		return r;
	endfunction

	function automatic lex_out_t mk_close(input status_t st);
		lex_out_t r;
		r.status       = st;
		r.token_kind   = TK_VAR;
		r.start_pos    = '0;
		r.end_pos      = '0;
		r.final_result = 1'b1;
		return r;
	endfunction

endpackage

/* sv/expression_lexer.sv */
// ----------------------------------------------------------------------------
// expression_lexer
// Byte-at-a-time tokenizer for expression lines with position tracking.
// ----------------------------------------------------------------------------
// Input channel (char_valid / char_stall / char_item): one byte per item,
// end_of_line set on the last byte of a line.
// Output channel (tok_valid / tok_stall / tok_item): tokens with kind and
// start/end index within the line, then one closing item per line (done,
// bad number, lone bang or line too long) with final_result set.
// Each accepted byte is decoded in the accept cycle against the lexer state
// and its 0 to 3 result items are written into a 4-entry output queue.
// Result items are registered in the queue and presented from it in order.
// Throughput: one byte per cycle while bytes yield at most one item each and tok_stall is low.
// Bytes yielding two or three items (such as a token plus a close) hold
// char_stall while the queue drains at one item per cycle with tok_stall low.
// char_stall is set whenever the queue holds more than one item, so a
// stalled receiver backs up into the input side.
// Reset empties the queue and returns the lexer to idle at position 0.
// Line length limit is MAX_LINE bytes; positions are reported in 17 bits.
// ----------------------------------------------------------------------------
module expression_lexer
	import exlex_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_stall,
	input  lex_in_t  char_item,
	output logic     tok_valid,
	input  logic     tok_stall,
	output lex_out_t tok_item
);

	mode_t            mode_q, mode_n;
	logic [CNT_W-1:0] start_q, start_n;
	logic [CNT_W-1:0] pos_q, pos_n;
	logic             dot_q, dot_n;
	kw_t              kw_q, kw_n;
	logic             disc_q, disc_n;

	lex_out_t         res [MAX_RES];
	logic [1:0]       nres;

	lex_out_t         fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;

	logic accept, pop;

	function automatic flush_t do_flush(input mode_t m, input logic [CNT_W-1:0] s,
			input kw_t kw, input logic [CNT_W-1:0] e);
		flush_t f;
		f.emit   = 1'b1;
		f.closes = 1'b0;
		f.item   = mk_token(TK_VAR, '0, '0);
		unique case (m)
			MODE_NAME: f.item = mk_token(kw_kind(kw), s, e);
			MODE_NUM:  f.item = mk_token(TK_NUM, s, e);
			MODE_EQ:   f.item = mk_token(TK_ASSIGN, s, s + CNT_W'(1));
			MODE_LT:   f.item = mk_token(TK_LT, s, s + CNT_W'(1));
			MODE_GT:   f.item = mk_token(TK_GT, s, s + CNT_W'(1));
			MODE_BANG: begin
				f.item   = mk_close(ST_BANG);
				f.closes = 1'b1;
			end
			default:   f.emit = 1'b0;
		endcase
		return f;
	endfunction

	assign char_stall = cnt_q > FCNT_W'(FIFO_DEPTH - MAX_RES);
	assign accept     = char_valid && !char_stall;
	assign tok_valid  = cnt_q != '0;
	assign tok_item   = fifo_q[rd_ptr_q];
	assign pop        = tok_valid && !tok_stall;

	always_comb begin
		logic [7:0] c;
		logic       eol;
		logic       closed;
		logic       consumed;
		flush_t     f;
		c        = char_item.char_in;
		eol      = char_item.end_of_line;
		closed   = 1'b0;
		consumed = 1'b0;
		f        = '0;
		nres     = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = mk_close(ST_DONE);
		end
		mode_n  = mode_q;
		start_n = start_q;
		pos_n   = pos_q;
		dot_n   = dot_q;
		kw_n    = kw_q;
		disc_n  = disc_q;

		if (disc_q) begin
			if (eol) begin
				disc_n = 1'b0;
				pos_n  = '0;
				mode_n = MODE_IDLE;
			end
		end else begin
			if (pos_q >= CNT_W'(MAX_LINE)) begin
				res[nres] = mk_close(ST_LONG);
				nres      = nres + 2'd1;
				closed    = 1'b1;
			end else begin
				unique case (mode_q)
					MODE_NAME: begin
						if (is_letter(c) || is_digit(c)) begin
							kw_n     = kw_next(kw_q, c);
							consumed = 1'b1;
						end
					end
					MODE_NUM: begin
						if (is_digit(c)) begin
							consumed = 1'b1;
						end else if (c == ".") begin
							if (dot_q) begin
								res[nres] = mk_close(ST_BADNUM);
								nres      = nres + 2'd1;
								closed    = 1'b1;
							end else begin
								dot_n    = 1'b1;
								consumed = 1'b1;
							end
						end
					end
					MODE_EQ, MODE_LT, MODE_GT, MODE_BANG: begin
						if (c == "=") begin
							priority case (mode_q)
								MODE_EQ: res[nres] = mk_token(TK_EQ, start_q,
									start_q + CNT_W'(2));
								MODE_LT: res[nres] = mk_token(TK_LE, start_q,
									start_q + CNT_W'(2));
								MODE_GT: res[nres] = mk_token(TK_GE, start_q,
									start_q + CNT_W'(2));
								default: res[nres] = mk_token(TK_NEQ, start_q,
									start_q + CNT_W'(2));
							endcase
							nres     = nres + 2'd1;
							mode_n   = MODE_IDLE;
							consumed = 1'b1;
						end
					end
					default: ;
				endcase

				if (!closed && !consumed) begin
					f = do_flush(mode_q, start_q, kw_q, pos_q);
					if (f.emit) begin
						res[nres] = f.item;
						nres      = nres + 2'd1;
					end
					closed = f.closes;
					mode_n = MODE_IDLE;
					if (!closed) begin
						if (c == "#") begin
							res[nres] = mk_close(ST_DONE);
							nres      = nres + 2'd1;
							closed    = 1'b1;
						end else if (is_letter(c)) begin
							mode_n  = MODE_NAME;
							start_n = pos_q;
							kw_n    = kw_first(c);
						end else if (is_digit(c)) begin
							mode_n  = MODE_NUM;
							start_n = pos_q;
							dot_n   = 1'b0;
						end else begin
							priority case (c)
								",": res[nres] = mk_token(TK_COMMA, pos_q, pos_q + CNT_W'(1));
								";": res[nres] = mk_token(TK_SEMI, pos_q, pos_q + CNT_W'(1));
								"(": res[nres] = mk_token(TK_LPAR, pos_q, pos_q + CNT_W'(1));
								")": res[nres] = mk_token(TK_RPAR, pos_q, pos_q + CNT_W'(1));
								"^": res[nres] = mk_token(TK_POW, pos_q, pos_q + CNT_W'(1));
								"*": res[nres] = mk_token(TK_MUL, pos_q, pos_q + CNT_W'(1));
								"/": res[nres] = mk_token(TK_DIV, pos_q, pos_q + CNT_W'(1));
								"+": res[nres] = mk_token(TK_ADD, pos_q, pos_q + CNT_W'(1));
								"-": res[nres] = mk_token(TK_SUB, pos_q, pos_q + CNT_W'(1));
								default: ;
							endcase
							priority case (c)
								",", ";", "(", ")", "^", "*", "/", "+", "-":
									nres = nres + 2'd1;
								"=", "<", ">", "!": begin
									start_n = pos_q;
									priority case (c)
										"=":     mode_n = MODE_EQ;
										"<":     mode_n = MODE_LT;
										">":     mode_n = MODE_GT;
										default: mode_n = MODE_BANG;
									endcase
								end
								default: ;
							endcase
						end
					end
				end

				if (!closed && eol) begin
					f = do_flush(mode_n, start_n, kw_n, pos_q + CNT_W'(1));
					if (f.emit) begin
						res[nres] = f.item;
						nres      = nres + 2'd1;
					end
					if (!f.closes) begin
						res[nres] = mk_close(ST_DONE);
						nres      = nres + 2'd1;
					end
					closed = 1'b1;
				end
			end

			if (closed) begin
				mode_n = MODE_IDLE;
				dot_n  = 1'b0;
				kw_n   = KW_NONE;
				if (eol) begin
					pos_n  = '0;
					disc_n = 1'b0;
				end else begin
					disc_n = 1'b1;
				end
			end else begin
				pos_n = pos_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			start_q  <= '0;
			pos_q    <= '0;
			dot_q    <= 1'b0;
			kw_q     <= KW_NONE;
			disc_q   <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				mode_q   <= mode_n;
				start_q  <= start_n;
				pos_q    <= pos_n;
				dot_q    <= dot_n;
				kw_q     <= kw_n;
				disc_q   <= disc_n;
				wr_ptr_q <= wr_ptr_q + PTR_W'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (accept ? FCNT_W'(nres) : '0) - FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (2'(i) < nres) begin
					fifo_q[wr_ptr_q + PTR_W'(i)] <= res[i];
				end
			end
		end
	end

endmodule

/* sv/exlex_checker.sv */
// ----------------------------------------------------------------------------
// exlex_checker
// Port-level checks on the result channel of the expression lexer.
// ----------------------------------------------------------------------------
module exlex_checker
	import exlex_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     tok_valid,
	input logic     tok_stall,
	input lex_out_t tok_item
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
		else $error("result item changed while stalled");

	a_final_iff_close: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_item.status == ST_TOKEN) == !tok_item.final_result))
		else $error("final_result does not match status");

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.final_result |->
			tok_item.token_kind == '0 && tok_item.start_pos == '0 &&
			tok_item.end_pos == '0)
		else $error("closing item carries token fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_item.status <= ST_LONG && tok_item.token_kind <= TK_ELSE)
		else $error("status or kind out of range");

endmodule

bind expression_lexer exlex_checker u_exlex_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_stall (tok_stall),
	.tok_item  (tok_item)
);
